[design/wur_pkg.sv]
// ----------------------------------------------------------------------------
// wur_pkg: shared constants and types for the weighted uniform remap block
// Field widths of the channels and the request/response bundle of the
// shared serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

package wur_pkg;

  localparam int unsigned DATA_W   = 32;  // sample and result width
  localparam int unsigned NUMW_W   = 5;   // num_weights register width
  localparam int unsigned WIDX_W   = 4;   // weight_index field width
  localparam int unsigned WVAL_W   = 16;  // weight_value field width
  localparam int unsigned DIVCNT_W = 6;   // holds DATA_W iterations

  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_LOAD   = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_ZERO_SUM = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage : wur_pkg

`default_nettype wire

[design/wur_if.sv]
// ----------------------------------------------------------------------------
// wur_if: valid/ready channel interfaces of the weighted uniform remap block
// One interface for the input transactions, one for the results.
// ----------------------------------------------------------------------------
`default_nettype none

interface wur_in_if;
  import wur_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [DATA_W-1:0]   sample_value;
  logic [WIDX_W-1:0]   weight_index;
  logic [WVAL_W-1:0]   weight_value;

  modport source (output valid, kind, sample_value, weight_index, weight_value,
                  input ready);
  modport sink   (input valid, kind, sample_value, weight_index, weight_value,
                  output ready);
endinterface : wur_in_if

interface wur_out_if;
  import wur_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] remapped;
  logic              status;

  modport source (output valid, remapped, status, input ready);
  modport sink   (input valid, remapped, status, output ready);
endinterface : wur_out_if

`default_nettype wire

[design/wur_weight_store.sv]
// ----------------------------------------------------------------------------
// wur_weight_store: weight table memory
// One write port, one registered read port. Per-entry valid bits cleared at
// reset make never-written entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module wur_weight_store #(
  parameter int unsigned MAX_WEIGHTS = 16,
  parameter int unsigned WEIGHT_BITS = 16,
  localparam int unsigned IDX_W = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   wr_en,
  input  wire logic [IDX_W-1:0]       wr_addr,
  input  wire logic [WEIGHT_BITS-1:0] wr_data,
  input  wire logic [IDX_W-1:0]       rd_addr,
  output logic      [WEIGHT_BITS-1:0] rd_data
);

  logic [WEIGHT_BITS-1:0] mem [MAX_WEIGHTS];
  logic [MAX_WEIGHTS-1:0] valid_r;
  logic [WEIGHT_BITS-1:0] rd_data_r;
  logic                   rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule : wur_weight_store

`default_nettype wire

[design/wur_divider.sv]
// ----------------------------------------------------------------------------
// wur_divider: shared serial unsigned divider
// Restoring division, one quotient bit per cycle. A start pulse loads the
// dividend (divisor read live); done pulses for one cycle with the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module wur_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire wur_pkg::div_req_t req,
  output wur_pkg::div_rsp_t      rsp
);
  import wur_pkg::*;

  logic [DATA_W-1:0]   rem_r, rem_nxt;
  logic [DATA_W-1:0]   quo_r, quo_nxt;
  logic [DIVCNT_W-1:0] cnt_r, cnt_nxt;
  logic                done_r, done_nxt;
  logic [DATA_W:0]     rem_shift;
  logic [DATA_W:0]     trial;

  always_comb begin
    rem_shift = {rem_r, quo_r[DATA_W-1]};
    trial     = rem_shift - {1'b0, req.divisor};
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    if (req.start) begin
      rem_nxt = '0;
      quo_nxt = req.dividend;
      cnt_nxt = DIVCNT_W'(DATA_W);
    end else if (cnt_r != '0) begin
      // take the trial difference when it does not go negative
      if (!trial[DATA_W]) begin
        rem_nxt = trial[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_shift[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == DIVCNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule : wur_divider

`default_nettype wire

[design/weighted_uniform_remap.sv]
// ----------------------------------------------------------------------------
// weighted_uniform_remap: piecewise uniform inverse-CDF remap
// Remaps a uniform 32-bit value through a table of integer bin weights,
// using one serial divider and one multiplier under a sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_if   | in  | valid/ready        | kind, sample_value, weight_index,
//          |     |                    | weight_value
//  out_if  | out | valid/ready        | remapped, status
//  cfg     | in  | cfg_wr_en          | cfg_wr_data (num_weights)
//
//  A load transaction gives no result and leaves the sequencer idle. A sample
//  that hits a bin makes four passes of the serial divider, one that runs
//  past the last bin makes one and a zero weight sum none. in_if.ready is
//  high only while the sequencer is idle; a finished result waits in the
//  output register and stalls only the final step of the next sample. Reset
//  clears the weight table (valid bits), num_weights to 1 and all handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_uniform_remap #(
  parameter int unsigned MAX_WEIGHTS = 16,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  wur_in_if.sink                          in_if,
  wur_out_if.source                       out_if,
  input  wire logic                       cfg_wr_en,
  input  wire logic [wur_pkg::NUMW_W-1:0] cfg_wr_data
);
  import wur_pkg::*;

  localparam int unsigned IDX_W = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SUM_RD   = 4'd1;
  localparam logic [3:0] S_SUM_ACC  = 4'd2;
  localparam logic [3:0] S_DIV      = 4'd3;
  localparam logic [3:0] S_WALK_RD  = 4'd4;
  localparam logic [3:0] S_WALK_LAT = 4'd5;
  localparam logic [3:0] S_MUL      = 4'd6;
  localparam logic [3:0] S_MUL_USE  = 4'd7;
  localparam logic [3:0] S_FINISH   = 4'd8;

  localparam logic [1:0] DT_STEP  = 2'd0;
  localparam logic [1:0] DT_OSTEP = 2'd1;
  localparam logic [1:0] DT_QUO   = 2'd2;
  localparam logic [1:0] DT_OFF   = 2'd3;

  localparam logic [1:0] MT_SPAN = 2'd0;
  localparam logic [1:0] MT_OFF  = 2'd1;
  localparam logic [1:0] MT_BASE = 2'd2;

  logic [3:0]             state_r, state_nxt;
  logic [NUMW_W-1:0]      num_weights_r;
  logic [DATA_W-1:0]      u_r, u_nxt;
  logic [NUMW_W-1:0]      n_r, n_nxt;
  logic [NUMW_W-1:0]      i_r, i_nxt;
  logic [DATA_W-1:0]      sum_r, sum_nxt;
  logic [DATA_W-1:0]      step_r, step_nxt;
  logic [DATA_W-1:0]      ostep_r, ostep_nxt;
  logic [DATA_W-1:0]      quo_r, quo_nxt;
  logic [DATA_W-1:0]      off_r, off_nxt;
  logic [WEIGHT_BITS-1:0] w_r, w_nxt;
  logic [DATA_W-1:0]      mul_p_r, mul_p_nxt;
  logic [DATA_W-1:0]      res_r, res_nxt;
  logic                   status_r, status_nxt;
  logic [1:0]             div_tag_r, div_tag_nxt;
  logic [1:0]             mul_tag_r, mul_tag_nxt;
  div_req_t               div_req_r, div_req_nxt;
  div_rsp_t               div_rsp;
  logic                   out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]      out_remapped_r, out_remapped_nxt;
  logic                   out_status_r, out_status_nxt;

  logic                   in_accept;
  logic                   wr_en;
  logic [WEIGHT_BITS-1:0] rd_data;
  logic [DATA_W-1:0]      mul_a, mul_b;
  logic [DATA_W-1:0]      sum_add;
  logic                   last_bin;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_accept   = in_if.valid && in_if.ready;
  assign wr_en       = in_accept && (in_if.kind == KIND_LOAD) &&
                       (32'(in_if.weight_index) < MAX_WEIGHTS);

  wur_weight_store #(
    .MAX_WEIGHTS (MAX_WEIGHTS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(in_if.weight_index)),
    .wr_data (WEIGHT_BITS'(in_if.weight_value)),
    .rd_addr (IDX_W'(i_r)),
    .rd_data (rd_data)
  );

  wur_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  // shared multiplier operands, low 32 bits of the product are kept
  always_comb begin
    unique case (mul_tag_r)
      MT_SPAN: begin
        mul_a = DATA_W'(w_r);
        mul_b = step_r;
      end
      MT_OFF: begin
        mul_a = sum_r;
        mul_b = quo_r;
      end
      MT_BASE: begin
        mul_a = ostep_r;
        mul_b = DATA_W'(i_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sum_add  = sum_r + DATA_W'(rd_data);
  assign last_bin = (i_r == n_r - 1'b1);

  always_comb begin
    state_nxt        = state_r;
    u_nxt            = u_r;
    n_nxt            = n_r;
    i_nxt            = i_r;
    sum_nxt          = sum_r;
    step_nxt         = step_r;
    ostep_nxt        = ostep_r;
    quo_nxt          = quo_r;
    off_nxt          = off_r;
    w_nxt            = w_r;
    mul_p_nxt        = mul_p_r;
    res_nxt          = res_r;
    status_nxt       = status_r;
    div_tag_nxt      = div_tag_r;
    mul_tag_nxt      = mul_tag_r;
    div_req_nxt      = div_req_r;
    div_req_nxt.start = 1'b0;
    out_valid_nxt    = out_valid_r;
    out_remapped_nxt = out_remapped_r;
    out_status_nxt   = out_status_r;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept && (in_if.kind == KIND_SAMPLE)) begin
          u_nxt   = in_if.sample_value;
          i_nxt   = '0;
          sum_nxt = '0;
          if (32'(num_weights_r) > MAX_WEIGHTS) begin
            n_nxt = NUMW_W'(MAX_WEIGHTS);
          end else begin
            n_nxt = num_weights_r;
          end
          if (num_weights_r == '0) begin
            res_nxt    = ALL_ONES;
            status_nxt = STATUS_ZERO_SUM;
            state_nxt  = S_FINISH;
          end else begin
            state_nxt = S_SUM_RD;
          end
        end
      end
      S_SUM_RD: begin
        state_nxt = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        sum_nxt = sum_add;
        if (last_bin) begin
          i_nxt = '0;
          if (sum_add == '0) begin
            res_nxt    = ALL_ONES;
            status_nxt = STATUS_ZERO_SUM;
            state_nxt  = S_FINISH;
          end else begin
            div_req_nxt = '{start: 1'b1, dividend: ALL_ONES, divisor: sum_add};
            div_tag_nxt = DT_STEP;
            state_nxt   = S_DIV;
          end
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SUM_RD;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          unique case (div_tag_r)
            DT_STEP: begin
              step_nxt  = div_rsp.quotient;
              state_nxt = S_WALK_RD;
            end
            DT_OSTEP: begin
              ostep_nxt   = div_rsp.quotient;
              div_req_nxt = '{start: 1'b1, dividend: u_r, divisor: DATA_W'(w_r)};
              div_tag_nxt = DT_QUO;
            end
            DT_QUO: begin
              quo_nxt     = div_rsp.quotient;
              mul_tag_nxt = MT_OFF;
              state_nxt   = S_MUL;
            end
            DT_OFF: begin
              off_nxt     = div_rsp.quotient;
              mul_tag_nxt = MT_BASE;
              state_nxt   = S_MUL;
            end
            default: begin
              state_nxt = S_DIV;
            end
          endcase
        end
      end
      S_WALK_RD: begin
        state_nxt = S_WALK_LAT;
      end
      S_WALK_LAT: begin
        w_nxt       = rd_data;
        mul_tag_nxt = MT_SPAN;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        mul_p_nxt = mul_a * mul_b;
        state_nxt = S_MUL_USE;
      end
      S_MUL_USE: begin
        unique case (mul_tag_r)
          MT_SPAN: begin
            if (u_r < mul_p_r) begin
              // hit bin: a nonzero span implies a nonzero weight
              div_req_nxt = '{start: 1'b1, dividend: ALL_ONES,
                              divisor: DATA_W'(n_r)};
              div_tag_nxt = DT_OSTEP;
              state_nxt   = S_DIV;
            end else begin
              u_nxt = u_r - mul_p_r;
              if (last_bin) begin
                res_nxt    = ALL_ONES;
                status_nxt = STATUS_OK;
                state_nxt  = S_FINISH;
              end else begin
                i_nxt     = i_r + 1'b1;
                state_nxt = S_WALK_RD;
              end
            end
          end
          MT_OFF: begin
            div_req_nxt = '{start: 1'b1, dividend: mul_p_r, divisor: DATA_W'(n_r)};
            div_tag_nxt = DT_OFF;
            state_nxt   = S_DIV;
          end
          MT_BASE: begin
            res_nxt    = mul_p_r + off_r;
            status_nxt = STATUS_OK;
            state_nxt  = S_FINISH;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt    = 1'b1;
          out_remapped_nxt = res_r;
          out_status_nxt   = status_r;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    u_r                <= u_nxt;
    n_r                <= n_nxt;
    i_r                <= i_nxt;
    sum_r              <= sum_nxt;
    step_r             <= step_nxt;
    ostep_r            <= ostep_nxt;
    quo_r              <= quo_nxt;
    off_r              <= off_nxt;
    w_r                <= w_nxt;
    mul_p_r            <= mul_p_nxt;
    res_r              <= res_nxt;
    status_r           <= status_nxt;
    div_tag_r          <= div_tag_nxt;
    mul_tag_r          <= mul_tag_nxt;
    out_remapped_r     <= out_remapped_nxt;
    out_status_r       <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      div_req_r       <= '0;
      out_valid_r     <= 1'b0;
      num_weights_r   <= NUMW_W'(1);
    end else begin
      state_r         <= state_nxt;
      div_req_r       <= div_req_nxt;
      out_valid_r     <= out_valid_nxt;
      if (cfg_wr_en) begin
        num_weights_r <= cfg_wr_data;
      end
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.remapped = out_remapped_r;
  assign out_if.status   = out_status_r;

endmodule : weighted_uniform_remap

`default_nettype wire

[tb/sv/weighted_uniform_remap_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_uniform_remap_tb: self-checking testbench for the weighted remap
// Sends weight loads and samples with random idle on both channels. A private
// copy of the weight table and count predicts each sample. Results are
// compared with the predictions field by field, in order of arrival.
// ----------------------------------------------------------------------------
module weighted_uniform_remap_tb;
  import wur_pkg::*;

  localparam int unsigned     BINS          = 16;
  localparam int unsigned     ITEM_TARGET   = 1500;
  localparam int unsigned     SETTLE_CYCLES = 300;
  localparam int unsigned     PRESSURE_AT   = 40;
  localparam int unsigned     PRESSURE_HOLD = 1500;
  localparam longint unsigned TIMEOUT_NS    = 60_000_000;

  typedef struct packed {
    logic [DATA_W-1:0] remapped;
    logic              status;
  } remap_result_t;

  class remap_scoreboard;
    logic [WVAL_W-1:0] weights [BINS];
    logic [NUMW_W-1:0] count_reg;
    remap_result_t     expected_q [$];
    int unsigned       mismatches;
    int unsigned       results_checked;

    function new();
      foreach (weights[i]) weights[i] = '0;
      count_reg       = 1;
      mismatches      = 0;
      results_checked = 0;
    endfunction

    function void set_count(logic [NUMW_W-1:0] value);
      count_reg = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_input(logic kind, logic [DATA_W-1:0] value,
                             logic [WIDX_W-1:0] idx, logic [WVAL_W-1:0] weight);
      remap_result_t     res;
      logic [DATA_W-1:0] n, total, step, span, w, rest;
      int unsigned       i;
      bit                hit;
      if (kind == KIND_LOAD) begin
        if (idx < BINS) weights[idx] = weight;
        return;
      end
      n = (count_reg > BINS) ? BINS : DATA_W'(count_reg);
      total = '0;
      for (i = 0; i < n; i++) total = total + DATA_W'(weights[i]);
      res.remapped = ALL_ONES;
      res.status   = STATUS_OK;
      if (total == '0) begin
        res.status = STATUS_ZERO_SUM;
      end else begin
        step = ALL_ONES / total;
        rest = value;
        hit  = 1'b0;
        // walk the bins; a zero-weight bin has zero span and is skipped
        for (i = 0; i < n && !hit; i++) begin
          w    = DATA_W'(weights[i]);
          span = w * step;
          if (rest < span) begin
            res.remapped = (ALL_ONES / n) * i + (total * (rest / w)) / n;
            hit = 1'b1;
          end else begin
            rest = rest - span;
          end
        end
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [DATA_W-1:0] remapped, logic status);
      remap_result_t exp_res;
      results_checked++;
      if (expected_q.size() == 0) begin
        $error("unexpected result: remapped %h status %b", remapped, status);
        mismatches++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (remapped !== exp_res.remapped) begin
        $error("remapped: expected %h, actual %h", exp_res.remapped, remapped);
        mismatches++;
      end
      if (status !== exp_res.status) begin
        $error("status: expected %b, actual %b", exp_res.status, status);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [NUMW_W-1:0] cfg_wr_data;
  int unsigned       items_sent = 0;
  bit                sender_calm = 1'b0;
  remap_scoreboard   sb = new();

  wur_in_if  in_if ();
  wur_out_if out_if ();

  weighted_uniform_remap DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_result(out_if.remapped, out_if.status);
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      sb.note_input(in_if.kind, in_if.sample_value, in_if.weight_index,
                    in_if.weight_value);
    end
  end

  // mostly short gaps, a few long ones; never zero
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [WVAL_W-1:0] pick_weight();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return '0;
    if (r < 35) return '1;
    if (r < 65) return WVAL_W'($urandom_range(1, 15));
    return WVAL_W'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [DATA_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return ALL_ONES;
    if (r < 25) return $urandom_range(0, 255);
    return $urandom;
  endfunction

  task automatic send_item(input logic kind, input logic [DATA_W-1:0] value,
                           input logic [WIDX_W-1:0] idx,
                           input logic [WVAL_W-1:0] weight);
    int unsigned gap;
    gap = (!sender_calm && $urandom_range(0, 99) < 40) ? idle_len() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.kind         <= kind;
    in_if.sample_value <= value;
    in_if.weight_index <= idx;
    in_if.weight_value <= weight;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic send_sample(input logic [DATA_W-1:0] value);
    send_item(KIND_SAMPLE, value, WIDX_W'($urandom_range(0, BINS - 1)),
              WVAL_W'($urandom_range(0, 16'hFFFF)));
  endtask

  task automatic send_load(input logic [WIDX_W-1:0] idx,
                           input logic [WVAL_W-1:0] weight);
    send_item(KIND_LOAD, $urandom, idx, weight);
  endtask

  // drop valid, wait for every pending result, then let the sequencer go idle
  task automatic settle_block();
    in_if.valid <= 1'b0;
    // let the monitor note the last accepted transaction first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [NUMW_W-1:0] value);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    sb.set_count(value);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned len);
    logic [NUMW_W-1:0] count;
    int unsigned       r, k, loads;
    r = $urandom_range(0, 99);
    if (r < 10)      count = NUMW_W'(BINS);
    else if (r < 15) count = NUMW_W'($urandom_range(BINS + 1, 31));
    else if (r < 18) count = '0;
    else if (r < 40) count = NUMW_W'($urandom_range(1, 4));
    else             count = NUMW_W'($urandom_range(1, BINS));
    settle_block();
    write_count(count);
    sender_calm = ($urandom_range(0, 99) < 20);
    // fill the active entries first, then mix samples with stray loads
    loads = (count > BINS) ? BINS : 32'(count);
    for (k = 0; k < loads; k++) send_load(WIDX_W'(k), pick_weight());
    for (k = loads; k < len; k++) begin
      if ($urandom_range(0, 99) < 15)
        send_load(WIDX_W'($urandom_range(0, BINS - 1)), pick_weight());
      else send_sample(pick_sample());
    end
  endtask

  initial begin : result_sink
    int unsigned stall_left, calm_left;
    bit          pressure_done;
    stall_left    = 0;
    calm_left     = 0;
    pressure_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      // hold off once for a long stretch so the block backs up its input
      if (!pressure_done && sb.results_checked >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        stall_left    = PRESSURE_HOLD;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 99) < 2) calm_left = $urandom_range(200, 1500);
        else if ($urandom_range(0, 99) < 20) stall_left = idle_len();
      end
    end
  end

  initial begin : stimulus
    rst_n              <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    in_if.valid        <= 1'b0;
    in_if.kind         <= KIND_SAMPLE;
    in_if.sample_value <= '0;
    in_if.weight_index <= '0;
    in_if.weight_value <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table after reset gives the zero-sum error
    send_sample('0);
    send_load(0, '1);
    send_sample('0);
    send_sample(ALL_ONES);
    send_sample(32'h7FFF_FFFF);

    // full table with zero-weight bins between the loaded ones
    settle_block();
    write_count(NUMW_W'(BINS));
    send_load(15, 1);
    send_load(1, 3);
    send_sample('0);
    send_sample(ALL_ONES);
    send_sample(32'h1234_5678);
    send_sample(32'hFFFF_0000);

    // count zero
    settle_block();
    write_count(0);
    send_sample(32'h5555_5555);

    // counts above the table saturate
    settle_block();
    write_count(31);
    send_sample(32'hFFFF_FFFE);
    send_load(15, 0);
    send_sample($urandom);
    settle_block();
    write_count(NUMW_W'(BINS + 1));
    send_sample(32'hA5A5_A5A5);

    // clear the active entries for a zero sum, then load one heavy bin
    settle_block();
    write_count(3);
    send_load(0, 0);
    send_load(1, 0);
    send_sample(ALL_ONES);
    send_load(2, 16'h8000);
    send_sample(32'h0000_0001);

    while (items_sent < ITEM_TARGET) run_phase($urandom_range(40, 120));

    settle_block();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule : weighted_uniform_remap_tb

[files.f]
design/wur_pkg.sv
design/wur_if.sv
design/wur_weight_store.sv
design/wur_divider.sv
design/weighted_uniform_remap.sv
tb/sv/weighted_uniform_remap_tb.sv
